@@ hw/rtl/led_pixel_buffer_brightness_core_assert.svh @@
// Assertion helpers for the pixel buffer core.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef LED_PIXEL_BUFFER_BRIGHTNESS_CORE_ASSERT_SVH
`define LED_PIXEL_BUFFER_BRIGHTNESS_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPBB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpbb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LPBB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpbb: next-cycle check failed");

`endif

@@ hw/rtl/lpbb_pkg.sv @@
package lpbb_pkg;

	localparam int MAX_LEDS_DEF = 256;

	localparam int S_TDATA_W   = 64;
	localparam int S_TUSER_W   = 3;
	localparam int M_TDATA_W   = 8;
	localparam int M_TUSER_W   = 1;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 9;

	localparam int BYTES_W = 11;
	localparam int DIV_W   = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_ORDER = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LED_COUNT   = 1'b1;

	localparam logic [7:0] PIXEL_ORDER_RST = 8'd82;

	typedef enum logic [2:0] {
		OP_SET_RGB    = 3'd0,
		OP_SET_RGBW   = 3'd1,
		OP_SET_BRIGHT = 3'd2,
		OP_CLEAR      = 3'd3,
		OP_READ       = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_SCALE_RD,
		ST_SCALE_WR,
		ST_CLR,
		ST_PIX,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ASEL_CNT,
		ASEL_PIX,
		ASEL_READ
	} addr_sel_t;

	typedef enum logic [1:0] {
		WSEL_ZERO,
		WSEL_PIX,
		WSEL_SCALE
	} wr_sel_t;

	typedef struct packed {
		logic      load;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      we;
		addr_sel_t asel;
		wr_sel_t   wsel;
		logic      div_start;
		logic      code_load;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       pix_ok;
		logic       same_code;
		logic       bytes_zero;
		logic       cnt_last;
		logic       sweep_last;
		logic       pix_last;
		logic       div_done;
		logic       out_free;
	} sts_t;

endpackage

@@ hw/rtl/lpbb_ram.sv @@
module lpbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/lpbb_div.sv @@
module lpbb_div import lpbb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [7:0]       divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIV_W);

	logic [DIV_W-1:0]  quo_q;
	logic [7:0]        rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [8:0]        shifted;
	logic [8:0]        diff;
	logic              fits;

	// One restoring step per cycle: the dividend shifts out of the top of
	// quo_q while quotient bits shift in at the bottom.
	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		fits    = shifted >= {1'b0, divisor};
		diff    = shifted - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[7:0] : shifted[7:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hw/rtl/lpbb_dp.sv @@
module lpbb_dp import lpbb_pkg::*; #(
	parameter int MAX_LEDS = MAX_LEDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic [S_TDATA_W-1:0]   s_tdata,
	input  logic [S_TUSER_W-1:0]   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata,
	output logic [M_TUSER_W-1:0]   m_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int STORE_BYTES = MAX_LEDS * 4;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int CNT_W       = (ADDR_W > BYTES_W) ? ADDR_W : BYTES_W;
	localparam int CMP_W       = CNT_W + 1;

	// Captured item
	logic [2:0]  op_q;
	logic [7:0]  led_q;
	logic [9:0]  bi_q;
	logic [7:0]  red_q, green_q, blue_q, white_q, level_q;

	logic [7:0]       order_q;
	logic [8:0]       count_q;
	logic [7:0]       code_q;
	logic [CNT_W-1:0] cnt_q;

	logic                 m_valid_q;
	logic [7:0]           m_data_q;
	logic                 m_ign_q;

	logic                 bpp4;
	logic [8:0]           pix_n;
	logic [BYTES_W-1:0]   bytes;
	logic [BYTES_W-1:0]   base;
	logic [BYTES_W-1:0]   pix_addr;
	logic [1:0]           step;
	logic [1:0]           off;
	logic [7:0]           chan;
	logic [15:0]          pix_prod;
	logic [7:0]           pix_val;
	logic                 pix_we_ok;
	logic                 pix_ok;
	logic                 read_ok;
	logic                 is_set;
	logic [7:0]           old_code;
	logic [DIV_W-1:0]     quotient;
	logic [DIV_W-1:0]     scale;
	logic                 div_done;
	logic [23:0]          scale_prod;
	logic [ADDR_W-1:0]    ram_addr;
	logic [7:0]           ram_wdata;
	logic [7:0]           ram_rdata;
	logic                 ram_we;
	logic                 res_ign;
	logic [7:0]           res_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= PIXEL_ORDER_RST;
			count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PIXEL_ORDER: order_q <= cfg_data[7:0];
				CFG_LED_COUNT:   count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= s_tuser;
			led_q   <= s_tdata[7:0];
			bi_q    <= s_tdata[17:8];
			red_q   <= s_tdata[25:18];
			green_q <= s_tdata[33:26];
			blue_q  <= s_tdata[41:34];
			white_q <= s_tdata[49:42];
			level_q <= s_tdata[57:50];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.code_load) begin
				code_q <= level_q + 8'd1;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Strip geometry: a pixel has no white byte when white and red share an offset.
	always_comb begin
		bpp4     = order_q[7:6] != order_q[5:4];
		pix_n    = (32'(count_q) > MAX_LEDS) ? 9'(MAX_LEDS) : count_q;
		bytes    = bpp4 ? {pix_n, 2'b00} : ({2'b00, pix_n} + {1'b0, pix_n, 1'b0});
		base     = bpp4 ? {1'b0, led_q, 2'b00} : ({3'b000, led_q} + {2'b00, led_q, 1'b0});
		pix_ok   = {1'b0, led_q} < pix_n;
		read_ok  = {1'b0, bi_q} < bytes;
	end

	// Pixel write steps go white, red, green, blue; offsets sit high to low in order_q.
	always_comb begin
		step      = cnt_q[1:0];
		off       = order_q[{~step, 1'b0} +: 2];
		pix_addr  = base + BYTES_W'(off);
		case (step)
			2'd0:    chan = (op_q == OP_SET_RGBW) ? white_q : 8'd0;
			2'd1:    chan = red_q;
			2'd2:    chan = green_q;
			default: chan = blue_q;
		endcase
		pix_prod  = chan * code_q;
		pix_val   = (code_q == 8'd0) ? chan : pix_prod[15:8];
		pix_we_ok = ((step != 2'd0) || bpp4) && (pix_addr < bytes);
	end

	assign old_code = code_q - 8'd1;

	lpbb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({level_q, 8'hFF}),
		.divisor  (old_code),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		scale      = (old_code == 8'd0) ? '0 : quotient;
		scale_prod = ram_rdata * scale;
	end

	always_comb begin
		case (cmd.asel)
			ASEL_CNT: ram_addr = ADDR_W'(cnt_q);
			ASEL_PIX: ram_addr = ADDR_W'(pix_addr);
			default:  ram_addr = ADDR_W'(bi_q);
		endcase
		case (cmd.wsel)
			WSEL_PIX:   ram_wdata = pix_val;
			WSEL_SCALE: ram_wdata = scale_prod[15:8];
			default:    ram_wdata = 8'd0;
		endcase
		ram_we = cmd.we && ((cmd.wsel != WSEL_PIX) || pix_we_ok);
	end

	lpbb_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		is_set = (op_q == OP_SET_RGB) || (op_q == OP_SET_RGBW);
		if (is_set) begin
			res_ign = !pix_ok;
		end else if (op_q == OP_READ) begin
			res_ign = !read_ok;
		end else begin
			res_ign = !((op_q == OP_SET_BRIGHT) || (op_q == OP_CLEAR));
		end
		res_data = ((op_q == OP_READ) && read_ok) ? ram_rdata : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_data_q <= res_data;
			m_ign_q  <= res_ign;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_ign_q;

	always_comb begin
		sts.op         = op_q;
		sts.pix_ok     = pix_ok;
		sts.same_code  = (level_q + 8'd1) == code_q;
		sts.bytes_zero = bytes == '0;
		sts.cnt_last   = ({1'b0, cnt_q} + 1'b1) == CMP_W'(bytes);
		sts.sweep_last = cnt_q == CNT_W'(STORE_BYTES - 1);
		sts.pix_last   = step == 2'd3;
		sts.div_done   = div_done;
		sts.out_free   = !m_valid_q || m_tready;
	end

endmodule

@@ hw/rtl/lpbb_ctrl.sv @@
module lpbb_ctrl import lpbb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	output logic   s_tready,
	input  sts_t   sts,
	output cmd_t   cmd,
	output state_t state
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (sts.op)
					OP_SET_RGB, OP_SET_RGBW: state_d = sts.pix_ok ? ST_PIX : ST_DONE;
					OP_SET_BRIGHT:           state_d = sts.same_code ? ST_DONE : ST_DIV;
					OP_CLEAR:                state_d = sts.bytes_zero ? ST_DONE : ST_CLR;
					default:                 state_d = ST_DONE;
				endcase
			end
			ST_DIV: begin
				if (sts.div_done) state_d = sts.bytes_zero ? ST_DONE : ST_SCALE_RD;
			end
			ST_SCALE_RD: state_d = ST_SCALE_WR;
			ST_SCALE_WR: state_d = sts.cnt_last ? ST_DONE : ST_SCALE_RD;
			ST_CLR: begin
				if (sts.cnt_last) state_d = ST_DONE;
			end
			ST_PIX: begin
				if (sts.pix_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.asel     = ASEL_READ;
		cmd.wsel     = WSEL_ZERO;
		s_tready     = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.asel    = ASEL_CNT;
				cmd.we      = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load    = s_tvalid;
				cmd.cnt_clr = 1'b1;
			end
			ST_DECODE: begin
				cmd.div_start = (sts.op == OP_SET_BRIGHT) && !sts.same_code;
			end
			ST_DIV: begin
				cmd.code_load = sts.div_done && sts.bytes_zero;
			end
			ST_SCALE_RD: begin
				cmd.asel = ASEL_CNT;
			end
			ST_SCALE_WR: begin
				cmd.asel      = ASEL_CNT;
				cmd.wsel      = WSEL_SCALE;
				cmd.we        = 1'b1;
				cmd.cnt_inc   = 1'b1;
				cmd.code_load = sts.cnt_last;
			end
			ST_CLR: begin
				cmd.asel    = ASEL_CNT;
				cmd.we      = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_PIX: begin
				cmd.asel    = ASEL_PIX;
				cmd.wsel    = WSEL_PIX;
				cmd.we      = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: ;
		endcase
	end

	assign state = state_q;

endmodule

@@ hw/rtl/led_pixel_buffer_brightness_core.sv @@
// Byte store for an addressable LED strip with a global brightness, built as a
// controller and a datapath around one byte-wide single-port RAM of 4*MAX_LEDS
// bytes. After reset the core zeroes every RAM byte and takes no word until
// that pass is done; configuration writes are taken throughout.
// One word is worked at a time and every op gives exactly one result word. Set
// pixel ops make one RAM write per channel. Clear zeroes every byte in use. A
// brightness change runs the 16-step divider that forms the scale factor, then
// reads, multiplies and writes back every byte in use through the single RAM
// port. The result register lets the next word be accepted while the previous
// result waits.
`include "led_pixel_buffer_brightness_core_assert.svh"

module led_pixel_buffer_brightness_core import lpbb_pkg::*; #(
	parameter int MAX_LEDS = MAX_LEDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// led_index[7:0], byte_index[17:8], red[25:18], green[33:26], blue[41:34],
	// white[49:42], level[57:50], zero fill [63:58]
	input  logic [S_TDATA_W-1:0]   s_tdata,
	// op[2:0]
	input  logic [S_TUSER_W-1:0]   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// read_data[7:0]
	output logic [M_TDATA_W-1:0]   m_tdata,
	// ignored[0]
	output logic [M_TUSER_W-1:0]   m_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	lpbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	lpbb_dp #(
		.MAX_LEDS (MAX_LEDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// An accepted word is always decoded in the following cycle.
	`LPBB_ASSERT_NEXT(a_accept_decode, s_tvalid && s_tready, state == ST_DECODE)
	// A result is only loaded when the output register can take it.
	`LPBB_ASSERT_SAME(a_load_free, cmd.out_load, sts.out_free)
	// Starting the divider drops its done flag for the next cycle.
	`LPBB_ASSERT_NEXT(a_div_restart, cmd.div_start, !sts.div_done)

endmodule
